// File: hdl/ippe_pkg.sv
package ippe_pkg;

	// Default width of one position
	localparam int POSITION_BITS = 20;

	// Configuration register widths and reset values
	localparam int MIN_OVERLAP_W  = 16;
	localparam int SHORT_DIFF_W   = 8;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 1;

	localparam logic [MIN_OVERLAP_W-1:0] MIN_OVERLAP_RESET = '0;
	localparam logic [SHORT_DIFF_W-1:0]  SHORT_DIFF_RESET  = 8'd20;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_OVERLAP    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_DIFFERENCE = 1'd1;

	// Layout classes of one interval pair (A = first, B = second interval)
	localparam int PATTERN_W     = 4;
	localparam int PATTERN_COUNT = 13;

	typedef enum logic [PATTERN_W-1:0] {
		PAT_GAP_AB           = 4'd0,   // A ends well before B starts
		PAT_TOUCH_AB         = 4'd1,   // A ends where B starts
		PAT_OVERLAP_AB       = 4'd2,   // A starts first, B ends last
		PAT_SAME_START_SHORT = 4'd3,   // shared start, A ends first
		PAT_SAME_END_LONG    = 4'd4,   // A starts first, shared end
		PAT_A_INSIDE         = 4'd5,   // A within B
		PAT_SAME             = 4'd6,   // shared start and end
		PAT_B_INSIDE         = 4'd7,   // B within A
		PAT_SAME_END_SHORT   = 4'd8,   // B starts first, shared end
		PAT_SAME_START_LONG  = 4'd9,   // shared start, B ends first
		PAT_OVERLAP_BA       = 4'd10,  // B starts first, A ends last
		PAT_TOUCH_BA         = 4'd11,  // B ends where A starts
		PAT_GAP_BA           = 4'd12,  // B ends well before A starts
		PAT_NONE             = 4'd13   // no class fits
	} pattern_t;

	// Compatibility of two classes: bit j of row i set when class i pairs with class j
	localparam logic [PATTERN_COUNT-1:0] COMPAT [PATTERN_COUNT] = '{
		13'b0_0000_0000_0011,
		13'b0_0000_0000_0111,
		13'b0_0000_0001_1110,
		13'b0_0000_0110_1100,
		13'b0_0000_1101_0100,
		13'b0_0001_0010_1000,
		13'b0_0011_0101_1000,
		13'b0_0010_1001_0000,
		13'b0_0101_0110_0000,
		13'b0_0110_1100_0000,
		13'b0_1111_0000_0000,
		13'b1_1100_0000_0000,
		13'b1_1000_0000_0000
	};

	// True when both classes are real classes and the table pairs them
	function automatic logic compat_ok(input pattern_t pa, input pattern_t pb);
		logic [PATTERN_COUNT-1:0] row;
		row = '0;
		if (pa != PAT_NONE && pb != PAT_NONE) begin
			row = COMPAT[pa];
		end
		return (pa != PAT_NONE && pb != PAT_NONE) ? row[pb] : 1'b0;
	endfunction

endpackage

// File: hdl/ippe_classify.sv
module ippe_classify #(
	parameter int POSITION_BITS = ippe_pkg::POSITION_BITS
) (
	input  logic [POSITION_BITS-1:0]              f1,
	input  logic [POSITION_BITS-1:0]              t1,
	input  logic [POSITION_BITS-1:0]              f2,
	input  logic [POSITION_BITS-1:0]              t2,
	input  logic [ippe_pkg::MIN_OVERLAP_W-1:0]    min_overlap,
	output ippe_pkg::pattern_t                    pattern,
	output logic signed [POSITION_BITS:0]         len0,
	output logic signed [POSITION_BITS:0]         len1,
	output logic signed [POSITION_BITS:0]         len2
);

	localparam int SW = ((POSITION_BITS > ippe_pkg::MIN_OVERLAP_W) ?
		POSITION_BITS : ippe_pkg::MIN_OVERLAP_W) + 1;
	localparam int LW = POSITION_BITS + 1;

	// p lies below q by more than the tolerance: p + tol < q
	function automatic logic below(input logic [POSITION_BITS-1:0] p,
			input logic [POSITION_BITS-1:0] q,
			input logic [ippe_pkg::MIN_OVERLAP_W-1:0] tol);
		logic [SW-1:0] s;
		s = SW'(p) + SW'(tol);
		return s < SW'(q);
	endfunction

	function automatic logic signed [LW-1:0] diff(input logic [POSITION_BITS-1:0] p,
			input logic [POSITION_BITS-1:0] q);
		return $signed({1'b0, p}) - $signed({1'b0, q});
	endfunction

	logic t1_lt_f2, f2_lt_t1, f1_lt_f2, f2_lt_f1;
	logic t1_lt_t2, t2_lt_t1, t2_lt_f1, f1_lt_t2;
	logic t1_eq_f2, f1_eq_f2, t1_eq_t2, t2_eq_f1;

	// Tolerant comparisons; equal means neither side is below the other
	always_comb begin
		t1_lt_f2 = below(t1, f2, min_overlap);
		f2_lt_t1 = below(f2, t1, min_overlap);
		f1_lt_f2 = below(f1, f2, min_overlap);
		f2_lt_f1 = below(f2, f1, min_overlap);
		t1_lt_t2 = below(t1, t2, min_overlap);
		t2_lt_t1 = below(t2, t1, min_overlap);
		t2_lt_f1 = below(t2, f1, min_overlap);
		f1_lt_t2 = below(f1, t2, min_overlap);
		t1_eq_f2 = !t1_lt_f2 && !f2_lt_t1;
		f1_eq_f2 = !f1_lt_f2 && !f2_lt_f1;
		t1_eq_t2 = !t1_lt_t2 && !t2_lt_t1;
		t2_eq_f1 = !t2_lt_f1 && !f1_lt_t2;
	end

	// Priority classification
	always_comb begin
		if (t1_lt_f2)                     pattern = ippe_pkg::PAT_GAP_AB;
		else if (t1_eq_f2)                pattern = ippe_pkg::PAT_TOUCH_AB;
		else if (f1_lt_f2 && t1_lt_t2)    pattern = ippe_pkg::PAT_OVERLAP_AB;
		else if (f1_eq_f2 && t1_lt_t2)    pattern = ippe_pkg::PAT_SAME_START_SHORT;
		else if (f1_lt_f2 && t1_eq_t2)    pattern = ippe_pkg::PAT_SAME_END_LONG;
		else if (f2_lt_f1 && t1_lt_t2)    pattern = ippe_pkg::PAT_A_INSIDE;
		else if (f1_eq_f2 && t1_eq_t2)    pattern = ippe_pkg::PAT_SAME;
		else if (f1_lt_f2 && t2_lt_t1)    pattern = ippe_pkg::PAT_B_INSIDE;
		else if (f2_lt_f1 && t1_eq_t2)    pattern = ippe_pkg::PAT_SAME_END_SHORT;
		else if (f1_eq_f2 && t2_lt_t1)    pattern = ippe_pkg::PAT_SAME_START_LONG;
		else if (f2_lt_f1 && t2_lt_t1)    pattern = ippe_pkg::PAT_OVERLAP_BA;
		else if (f2_lt_f1 && t2_eq_f1)    pattern = ippe_pkg::PAT_TOUCH_BA;
		else if (t2_lt_f1)                pattern = ippe_pkg::PAT_GAP_BA;
		else                              pattern = ippe_pkg::PAT_NONE;
	end

	// Gap and overlap lengths, exact (no tolerance)
	always_comb begin
		if (f1 < f2) begin
			if (f2 < t1) begin
				len0 = diff(f2, f1);
				if (t1 < t2) begin
					len1 = diff(t1, f2);
					len2 = diff(t2, t1);
				end else begin
					len1 = diff(t2, f2);
					len2 = diff(t1, t2);
				end
			end else begin
				len0 = diff(t1, f1);
				len1 = diff(f2, t1);
				len2 = diff(t2, f2);
			end
		end else begin
			if (f1 < t2) begin
				len0 = diff(f1, f2);
				if (t2 < t1) begin
					len1 = diff(t2, f1);
					len2 = diff(t1, t2);
				end else begin
					len1 = diff(t1, f1);
					len2 = diff(t2, t1);
				end
			end else begin
				len0 = diff(t2, f2);
				len1 = diff(f1, t2);
				len2 = diff(t1, f1);
			end
		end
	end

endmodule

// File: hdl/ippe_match.sv
module ippe_match #(
	parameter int POSITION_BITS = ippe_pkg::POSITION_BITS
) (
	input  ippe_pkg::pattern_t                  pattern_a,
	input  ippe_pkg::pattern_t                  pattern_b,
	input  logic signed [POSITION_BITS:0]       len_a0,
	input  logic signed [POSITION_BITS:0]       len_a1,
	input  logic signed [POSITION_BITS:0]       len_a2,
	input  logic signed [POSITION_BITS:0]       len_b0,
	input  logic signed [POSITION_BITS:0]       len_b1,
	input  logic signed [POSITION_BITS:0]       len_b2,
	input  logic [ippe_pkg::SHORT_DIFF_W-1:0]   short_difference,
	output logic                                equivalent
);

	localparam int LW = POSITION_BITS + 1;
	localparam int DW = LW + 1;

	// Two lengths are close: identical, a small difference, or smaller > half of larger
	function automatic logic close_len(input logic signed [LW-1:0] x,
			input logic signed [LW-1:0] y,
			input logic [ippe_pkg::SHORT_DIFF_W-1:0] sd);
		logic signed [DW-1:0] xe, ye, x2, y2, d;
		logic [DW-1:0] ad;
		logic ok;
		xe = $signed({x[LW-1], x});
		ye = $signed({y[LW-1], y});
		x2 = $signed({x, 1'b0});
		y2 = $signed({y, 1'b0});
		d  = xe - ye;
		ad = d[DW-1] ? $unsigned(-d) : $unsigned(d);
		if (d == '0 || ad < DW'(sd)) begin
			ok = 1'b1;
		end else if (xe > ye) begin
			if (!xe[DW-1] && xe != '0) begin
				ok = y2 > xe;
			end else begin
				ok = xe[DW-1];
			end
		end else begin
			if (!ye[DW-1] && ye != '0) begin
				ok = x2 > ye;
			end else begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	logic pat_ok;
	logic close0, close1, close2;

	always_comb begin
		pat_ok     = ippe_pkg::compat_ok(pattern_a, pattern_b);
		close0     = close_len(len_a0, len_b0, short_difference);
		close1     = close_len(len_a1, len_b1, short_difference);
		close2     = close_len(len_a2, len_b2, short_difference);
		equivalent = pat_ok && close0 && close1 && close2;
	end

endmodule

// File: hdl/interval_pair_pattern_equivalence_top.sv
// Channel   Direction  Handshake            Payload
// in        request    in_valid / in_ready  a1_start .. b2_end, POSITION_BITS each
// out       result     out_valid/out_ready  equivalent, pattern_a, pattern_b
// cfg       write      cfg_we               cfg_index, cfg_data
//
// One request per cycle sustained while out_ready keeps the output moving; a full stalled pipeline holds in_ready low.
// Three register stages: input, classify (both pairs), match result.
// Each stage moves on when the next one is empty or moving, so bubbles collapse.
// Reset clears all valid flags and loads the register reset values.
// A stalled output holds its result; up to three requests may be in flight.
module interval_pair_pattern_equivalence_top #(
	parameter int POSITION_BITS = ippe_pkg::POSITION_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [ippe_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ippe_pkg::CFG_DATA_W-1:0]      cfg_data,
	// requests
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [POSITION_BITS-1:0]             a1_start,
	input  logic [POSITION_BITS-1:0]             a1_end,
	input  logic [POSITION_BITS-1:0]             a2_start,
	input  logic [POSITION_BITS-1:0]             a2_end,
	input  logic [POSITION_BITS-1:0]             b1_start,
	input  logic [POSITION_BITS-1:0]             b1_end,
	input  logic [POSITION_BITS-1:0]             b2_start,
	input  logic [POSITION_BITS-1:0]             b2_end,
	// results
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 equivalent,
	output logic [ippe_pkg::PATTERN_W-1:0]       pattern_a,
	output logic [ippe_pkg::PATTERN_W-1:0]       pattern_b
);

	logic [ippe_pkg::MIN_OVERLAP_W-1:0] min_overlap_q;
	logic [ippe_pkg::SHORT_DIFF_W-1:0]  short_diff_q;

	logic                      v_s1, v_s2, out_valid_q;
	logic                      rdy_s2, rdy_o;
	logic [POSITION_BITS-1:0]  a1s_s1, a1e_s1, a2s_s1, a2e_s1;
	logic [POSITION_BITS-1:0]  b1s_s1, b1e_s1, b2s_s1, b2e_s1;

	ippe_pkg::pattern_t           pat_a_c, pat_b_c, pat_a_s2, pat_b_s2;
	logic signed [POSITION_BITS:0] la0_c, la1_c, la2_c, lb0_c, lb1_c, lb2_c;
	logic signed [POSITION_BITS:0] la0_s2, la1_s2, la2_s2, lb0_s2, lb1_s2, lb2_s2;

	logic                      eq_c, equivalent_q;
	ippe_pkg::pattern_t        pat_a_q, pat_b_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_overlap_q <= ippe_pkg::MIN_OVERLAP_RESET;
			short_diff_q  <= ippe_pkg::SHORT_DIFF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ippe_pkg::REG_MIN_OVERLAP:
					min_overlap_q <= cfg_data[ippe_pkg::MIN_OVERLAP_W-1:0];
				ippe_pkg::REG_SHORT_DIFFERENCE:
					short_diff_q <= cfg_data[ippe_pkg::SHORT_DIFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage flow control
	always_comb begin
		rdy_o    = !out_valid_q || out_ready;
		rdy_s2   = !v_s2 || rdy_o;
		in_ready = !v_s1 || rdy_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy_s2)   v_s2 <= v_s1;
			if (rdy_o)    out_valid_q <= v_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a1s_s1 <= a1_start;
			a1e_s1 <= a1_end;
			a2s_s1 <= a2_start;
			a2e_s1 <= a2_end;
			b1s_s1 <= b1_start;
			b1e_s1 <= b1_end;
			b2s_s1 <= b2_start;
			b2e_s1 <= b2_end;
		end
	end

	// Classify both pairs
	ippe_classify #(.POSITION_BITS(POSITION_BITS)) u_class_a (
		.f1(a1s_s1), .t1(a1e_s1), .f2(a2s_s1), .t2(a2e_s1),
		.min_overlap(min_overlap_q),
		.pattern(pat_a_c), .len0(la0_c), .len1(la1_c), .len2(la2_c)
	);

	ippe_classify #(.POSITION_BITS(POSITION_BITS)) u_class_b (
		.f1(b1s_s1), .t1(b1e_s1), .f2(b2s_s1), .t2(b2e_s1),
		.min_overlap(min_overlap_q),
		.pattern(pat_b_c), .len0(lb0_c), .len1(lb1_c), .len2(lb2_c)
	);

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			pat_a_s2 <= pat_a_c;
			pat_b_s2 <= pat_b_c;
			la0_s2   <= la0_c;
			la1_s2   <= la1_c;
			la2_s2   <= la2_c;
			lb0_s2   <= lb0_c;
			lb1_s2   <= lb1_c;
			lb2_s2   <= lb2_c;
		end
	end

	// Compatibility and length match
	ippe_match #(.POSITION_BITS(POSITION_BITS)) u_match (
		.pattern_a(pat_a_s2), .pattern_b(pat_b_s2),
		.len_a0(la0_s2), .len_a1(la1_s2), .len_a2(la2_s2),
		.len_b0(lb0_s2), .len_b1(lb1_s2), .len_b2(lb2_s2),
		.short_difference(short_diff_q),
		.equivalent(eq_c)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_o) begin
			equivalent_q <= eq_c;
			pat_a_q      <= pat_a_s2;
			pat_b_q      <= pat_b_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign equivalent = equivalent_q;
	assign pattern_a  = pat_a_q;
	assign pattern_b  = pat_b_q;

	// A match needs two classified, compatible layouts
	a_eq_needs_compat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && equivalent |-> ippe_pkg::compat_ok(pat_a_q, pat_b_q))
		else $error("equivalent set for incompatible layouts");

	// An accepted request always lands in the input stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted request lost at input stage");

	// A stalled middle stage keeps its item
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_o |=> v_s2 && $stable(pat_a_s2) && $stable(la0_s2))
		else $error("middle stage changed while stalled");

endmodule
